[rtl/core/abfx_pkg.sv]
// Shared types, constants and codes of the AUX bus frame exchange.
`default_nettype none

package abfx_pkg;

    // Sizing
    localparam int MAX_PAYLOAD = 8;
    localparam int RX_DEPTH    = MAX_PAYLOAD + 6;
    localparam int PAYLOAD_W   = 64;
    localparam int HDR_BYTES   = 5;
    localparam int IDX_W       = $clog2(RX_DEPTH);
    localparam int CNT_W       = $clog2(RX_DEPTH + 2);
    localparam int PSEL_W      = $clog2(MAX_PAYLOAD);
    localparam int TICK_W      = 17;
    localparam int QDEPTH      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Frame constants
    localparam logic [7:0]        PREAMBLE      = 8'h3b;
    localparam logic [7:0]        LEN_EXTRA     = 8'd3;
    localparam logic [7:0]        MAX_SIZE      = 8'(MAX_PAYLOAD);
    localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};
    localparam logic [7:0]        SOURCE_RESET  = 8'd4;
    localparam logic [15:0]       TIMEOUT_RESET = 16'd800;

    // Receive limits
    localparam logic [CNT_W-1:0] RX_FULL     = CNT_W'(RX_DEPTH);
    localparam logic [CNT_W-1:0] RX_SAT      = CNT_W'(RX_DEPTH + 1);
    localparam logic [CNT_W-1:0] RX_MIN      = CNT_W'(6);
    localparam logic [CNT_W-1:0] RX_LEN_POS  = CNT_W'(1);

    // Byte positions in a frame
    localparam logic [IDX_W-1:0] POS_PRE = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_LEN = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_SRC = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_DST = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_ID  = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_PAY = IDX_W'(HDR_BYTES);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b1;

    // Result kinds
    localparam logic OUT_BYTE   = 1'b0;
    localparam logic OUT_STATUS = 1'b1;

    typedef enum logic [1:0] {
        CMD_SEND,
        CMD_TICK,
        CMD_RX_BYTE,
        CMD_RX_END
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_INVALID,
        ST_TIMEOUT,
        ST_BAD_SIZE,
        ST_CHECKSUM
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_LOW,
        PH_WAIT_HIGH,
        PH_RECV
    } phase_t;

    typedef enum logic [1:0] {
        JOB_SEND,
        JOB_STATUS,
        JOB_CHECK
    } job_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SEND,
        B_STAT,
        B_WALK,
        B_CHECK
    } back_state_t;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [7:0]           dest;
        logic [7:0]           msg_id;
        logic [7:0]           size;
        logic [PAYLOAD_W-1:0] payload;
        logic [7:0]           rx_byte;
        logic                 busy_level;
    } in_t;

    typedef struct packed {
        logic                 out_kind;
        logic [7:0]           tx_byte;
        logic                 last;
        logic [2:0]           status;
        logic [7:0]           resp_length;
        logic [7:0]           resp_source;
        logic [7:0]           resp_dest;
        logic [7:0]           resp_id;
        logic [PAYLOAD_W-1:0] resp_payload;
    } out_t;

    // Work handed from front to back; size carries the length byte for a check
    typedef struct packed {
        job_kind_t            kind;
        status_t              status;
        logic [7:0]           src;
        logic [7:0]           dest;
        logic [7:0]           msg_id;
        logic [7:0]           size;
        logic [PAYLOAD_W-1:0] payload;
    } job_t;

    typedef struct packed {
        logic check_done;
    } back_stat_t;

endpackage

`default_nettype wire

[rtl/core/abfx_ifs.sv]
// Valid/ready channel interfaces for items and results.
`default_nettype none

interface abfx_item_if;
    logic           valid;
    logic           ready;
    abfx_pkg::in_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface abfx_result_if;
    logic           valid;
    logic           ready;
    abfx_pkg::out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/abfx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module abfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/abfx_queue.sv]
// Two-entry job queue between front and back.
`default_nettype none

module abfx_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  abfx_pkg::job_t      push_job,
    output logic                full,
    output logic                valid,
    output abfx_pkg::job_t      head,
    input  wire logic           pop
);

    localparam int PTR_W = (abfx_pkg::QDEPTH > 1) ? $clog2(abfx_pkg::QDEPTH) : 1;
    localparam int NUM_W = $clog2(abfx_pkg::QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(abfx_pkg::QDEPTH - 1);
    localparam logic [NUM_W-1:0] NUM_FULL = NUM_W'(abfx_pkg::QDEPTH);

    abfx_pkg::job_t   entry_reg [abfx_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NUM_W-1:0] num_reg, num_next;

    assign full  = (num_reg == NUM_FULL);
    assign valid = (num_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        num_next    = num_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            num_next = num_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            num_next = num_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            num_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            num_reg    <= num_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[rtl/core/abfx_front.sv]
// Front end: accepts items, tracks the exchange phase and fills the receive buffer.
`default_nettype none

module abfx_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    abfx_item_if.sink                                 item,
    input  wire logic                                 wr_en,
    input  wire logic [abfx_pkg::CFG_IDX_W-1:0]       wr_index,
    input  wire logic [abfx_pkg::CFG_DATA_W-1:0]      wr_data,
    output logic                                      q_push,
    output abfx_pkg::job_t                            q_job,
    input  wire logic                                 q_full,
    input  abfx_pkg::back_stat_t                      bstat,
    output logic                                      ram_we,
    output logic [abfx_pkg::IDX_W-1:0]                ram_waddr,
    output logic [7:0]                                ram_wdata
);

    abfx_pkg::phase_t                 phase_reg, phase_next;
    logic [abfx_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [abfx_pkg::TICK_W-1:0]      tick_inc;
    logic [abfx_pkg::CNT_W-1:0]       rx_cnt_reg, rx_cnt_next;
    logic [7:0]                       len_reg, len_next;
    logic                             pend_reg, pend_next;
    logic [7:0]                       src_reg, src_next;
    logic [15:0]                      timeout_reg, timeout_next;
    logic                             accept;
    logic [8:0]                       len_span;

    // Hold off new items while a checksum walk owns the buffer or the job queue is full
    assign item.ready = !pend_reg && !q_full;
    assign accept     = item.valid && item.ready;
    assign tick_inc   = (tick_reg == abfx_pkg::TICK_MAX) ? tick_reg : tick_reg + 1'b1;
    assign len_span   = {1'b0, len_reg} + 9'd2;

    assign ram_waddr  = rx_cnt_reg[abfx_pkg::IDX_W-1:0];
    assign ram_wdata  = item.data.rx_byte;

    // Classify the accepted item and update the exchange state
    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        rx_cnt_next    = rx_cnt_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        src_next       = src_reg;
        timeout_next   = timeout_reg;
        ram_we         = 1'b0;
        q_push         = 1'b0;
        q_job.kind     = abfx_pkg::JOB_STATUS;
        q_job.status   = abfx_pkg::ST_OK;
        q_job.src      = src_reg;
        q_job.dest     = item.data.dest;
        q_job.msg_id   = item.data.msg_id;
        q_job.size     = item.data.size;
        q_job.payload  = item.data.payload;

        if (accept)
        begin
            case (abfx_pkg::cmd_t'(item.data.cmd))
                abfx_pkg::CMD_SEND:
                begin
                    q_push = 1'b1;
                    if (item.data.size > abfx_pkg::MAX_SIZE)
                    begin
                        q_job.status = abfx_pkg::ST_INVALID;
                    end
                    else
                    begin
                        q_job.kind  = abfx_pkg::JOB_SEND;
                        phase_next  = abfx_pkg::PH_WAIT_LOW;
                        tick_next   = '0;
                        rx_cnt_next = '0;
                    end
                end
                abfx_pkg::CMD_TICK:
                begin
                    if (phase_reg == abfx_pkg::PH_WAIT_LOW ||
                        phase_reg == abfx_pkg::PH_WAIT_HIGH)
                    begin
                        tick_next = tick_inc;
                        if (phase_reg == abfx_pkg::PH_WAIT_LOW && !item.data.busy_level)
                        begin
                            phase_next = abfx_pkg::PH_WAIT_HIGH;
                        end
                        else if (phase_reg == abfx_pkg::PH_WAIT_HIGH &&
                                 item.data.busy_level)
                        begin
                            phase_next = abfx_pkg::PH_RECV;
                        end
                        else if (tick_inc > {1'b0, timeout_reg})
                        begin
                            phase_next   = abfx_pkg::PH_IDLE;
                            q_push       = 1'b1;
                            q_job.status = abfx_pkg::ST_TIMEOUT;
                        end
                    end
                end
                abfx_pkg::CMD_RX_BYTE:
                begin
                    if (phase_reg != abfx_pkg::PH_IDLE)
                    begin
                        if (rx_cnt_reg < abfx_pkg::RX_FULL)
                        begin
                            ram_we = 1'b1;
                        end
                        if (rx_cnt_reg == abfx_pkg::RX_LEN_POS)
                        begin
                            len_next = item.data.rx_byte;
                        end
                        if (rx_cnt_reg < abfx_pkg::RX_SAT)
                        begin
                            rx_cnt_next = rx_cnt_reg + 1'b1;
                        end
                    end
                end
                abfx_pkg::CMD_RX_END:
                begin
                    if (phase_reg == abfx_pkg::PH_RECV)
                    begin
                        phase_next = abfx_pkg::PH_IDLE;
                        q_push     = 1'b1;
                        if (rx_cnt_reg >= abfx_pkg::RX_FULL ||
                            rx_cnt_reg <= abfx_pkg::RX_MIN ||
                            len_span >= 9'(rx_cnt_reg))
                        begin
                            q_job.status = abfx_pkg::ST_BAD_SIZE;
                        end
                        else
                        begin
                            q_job.kind = abfx_pkg::JOB_CHECK;
                            q_job.size = len_reg;
                            pend_next  = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // Release the buffer once the back end reports the check
        if (bstat.check_done)
        begin
            pend_next = 1'b0;
        end

        // Configuration writes
        if (wr_en)
        begin
            case (wr_index)
                abfx_pkg::REG_SOURCE:  src_next     = wr_data[7:0];
                abfx_pkg::REG_TIMEOUT: timeout_next = wr_data;
                default:               src_next     = src_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= abfx_pkg::PH_IDLE;
            tick_reg    <= '0;
            rx_cnt_reg  <= '0;
            pend_reg    <= 1'b0;
            src_reg     <= abfx_pkg::SOURCE_RESET;
            timeout_reg <= abfx_pkg::TIMEOUT_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            rx_cnt_reg  <= rx_cnt_next;
            pend_reg    <= pend_next;
            src_reg     <= src_next;
            timeout_reg <= timeout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

`default_nettype wire

[rtl/core/abfx_back.sv]
// Back end: emits frame bytes and status beats, and walks the buffer for the response check.
`default_nettype none

module abfx_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  abfx_pkg::job_t                     q_job,
    output logic                               q_pop,
    output logic [abfx_pkg::IDX_W-1:0]         ram_raddr,
    input  wire logic [7:0]                    ram_rdata,
    output abfx_pkg::back_stat_t               bstat,
    abfx_result_if.source                      result
);

    abfx_pkg::back_state_t              state_reg, state_next;
    abfx_pkg::job_t                     job_reg, job_next;
    logic [abfx_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [7:0]                         sum_reg, sum_next;
    logic [abfx_pkg::CNT_W-1:0]         ptr_reg, ptr_next;
    logic [abfx_pkg::CNT_W-1:0]         d_reg, d_next;
    logic                               dvalid_reg, dvalid_next;
    logic [7:0]                         chk_reg, chk_next;
    logic [7:0]                         rlen_reg, rlen_next;
    logic [7:0]                         rsrc_reg, rsrc_next;
    logic [7:0]                         rdst_reg, rdst_next;
    logic [7:0]                         rid_reg, rid_next;
    logic [abfx_pkg::PAYLOAD_W-1:0]     rpay_reg, rpay_next;
    logic                               out_valid_reg, out_valid_next;
    abfx_pkg::out_t                     out_reg, out_next;

    logic                               out_free;
    logic                               send_last;
    logic [7:0]                         send_byte;
    logic [7:0]                         pay_byte;
    logic [abfx_pkg::IDX_W-1:0]         idx_off;
    logic [abfx_pkg::PSEL_W-1:0]        psel_tx;
    logic [abfx_pkg::CNT_W-1:0]         d_off;
    logic [abfx_pkg::PSEL_W-1:0]        psel_rx;
    logic [8:0]                         len_chk;
    logic [8:0]                         walk_end9;
    logic [abfx_pkg::CNT_W-1:0]         walk_end;
    logic                               walk_last;
    logic                               d_in_sum;

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;
    assign ram_raddr    = ptr_reg[abfx_pkg::IDX_W-1:0];
    assign out_free     = !out_valid_reg || result.ready;

    // Frame byte selection
    assign send_last = ({{(8 - abfx_pkg::IDX_W){1'b0}}, idx_reg} ==
                        job_reg.size + 8'(abfx_pkg::HDR_BYTES));
    assign idx_off   = idx_reg - abfx_pkg::POS_PAY;
    assign psel_tx   = idx_off[abfx_pkg::PSEL_W-1:0];

    always_comb
    begin
        pay_byte = '0;
        for (int k = 0; k < abfx_pkg::MAX_PAYLOAD; k++)
        begin
            if (psel_tx == abfx_pkg::PSEL_W'(k))
            begin
                pay_byte = job_reg.payload[8*k +: 8];
            end
        end
    end

    always_comb
    begin
        if (send_last)
        begin
            send_byte = 8'd0 - sum_reg;
        end
        else
        begin
            case (idx_reg)
                abfx_pkg::POS_PRE: send_byte = abfx_pkg::PREAMBLE;
                abfx_pkg::POS_LEN: send_byte = job_reg.size + abfx_pkg::LEN_EXTRA;
                abfx_pkg::POS_SRC: send_byte = job_reg.src;
                abfx_pkg::POS_DST: send_byte = job_reg.dest;
                abfx_pkg::POS_ID:  send_byte = job_reg.msg_id;
                default:           send_byte = pay_byte;
            endcase
        end
    end

    // Walk limits: header bytes always, checksum byte at length + 2
    assign len_chk   = {1'b0, job_reg.size} + 9'd2;
    assign walk_end9 = (len_chk > 9'(abfx_pkg::POS_ID)) ? len_chk : 9'(abfx_pkg::POS_ID);
    assign walk_end  = walk_end9[abfx_pkg::CNT_W-1:0];
    assign walk_last = dvalid_reg && (d_reg == walk_end);
    assign d_in_sum  = (9'(d_reg) < len_chk);
    assign d_off     = d_reg - abfx_pkg::CNT_W'(abfx_pkg::HDR_BYTES);
    assign psel_rx   = d_off[abfx_pkg::PSEL_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            abfx_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_job.kind)
                        abfx_pkg::JOB_SEND:  state_next = abfx_pkg::B_SEND;
                        abfx_pkg::JOB_CHECK: state_next = abfx_pkg::B_WALK;
                        default:             state_next = abfx_pkg::B_STAT;
                    endcase
                end
            end
            abfx_pkg::B_SEND:
            begin
                if (out_free && send_last)
                begin
                    state_next = abfx_pkg::B_IDLE;
                end
            end
            abfx_pkg::B_STAT:
            begin
                if (out_free)
                begin
                    state_next = abfx_pkg::B_IDLE;
                end
            end
            abfx_pkg::B_WALK:
            begin
                if (walk_last)
                begin
                    state_next = abfx_pkg::B_CHECK;
                end
            end
            abfx_pkg::B_CHECK:
            begin
                if (out_free)
                begin
                    state_next = abfx_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = abfx_pkg::B_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        job_next         = job_reg;
        idx_next         = idx_reg;
        sum_next         = sum_reg;
        ptr_next         = ptr_reg;
        d_next           = d_reg;
        dvalid_next      = 1'b0;
        chk_next         = chk_reg;
        rlen_next        = rlen_reg;
        rsrc_next        = rsrc_reg;
        rdst_next        = rdst_reg;
        rid_next         = rid_reg;
        rpay_next        = rpay_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_next         = out_reg;
        q_pop            = 1'b0;
        bstat.check_done = 1'b0;

        case (state_reg)
            abfx_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_job;
                    idx_next  = '0;
                    sum_next  = '0;
                    ptr_next  = abfx_pkg::CNT_W'(1);
                    rpay_next = '0;
                end
            end
            abfx_pkg::B_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.out_kind = abfx_pkg::OUT_BYTE;
                    out_next.tx_byte  = send_byte;
                    out_next.last     = send_last;
                    out_next.status   = abfx_pkg::ST_OK;
                    idx_next          = idx_reg + 1'b1;
                    if (idx_reg != abfx_pkg::POS_PRE)
                    begin
                        sum_next = sum_reg + send_byte;
                    end
                end
            end
            abfx_pkg::B_STAT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next          = '0;
                    out_next.out_kind = abfx_pkg::OUT_STATUS;
                    out_next.last     = 1'b1;
                    out_next.status   = job_reg.status;
                end
            end
            abfx_pkg::B_WALK:
            begin
                // Issue one read a cycle up to the last needed byte
                if (ptr_reg <= walk_end)
                begin
                    ptr_next    = ptr_reg + 1'b1;
                    d_next      = ptr_reg;
                    dvalid_next = 1'b1;
                end
                // Fold in the byte read last cycle
                if (dvalid_reg)
                begin
                    case (d_reg[abfx_pkg::IDX_W-1:0])
                        abfx_pkg::POS_LEN: rlen_next = ram_rdata;
                        abfx_pkg::POS_SRC: rsrc_next = ram_rdata;
                        abfx_pkg::POS_DST: rdst_next = ram_rdata;
                        abfx_pkg::POS_ID:  rid_next  = ram_rdata;
                        default:           rlen_next = rlen_reg;
                    endcase
                    if (d_in_sum)
                    begin
                        sum_next = sum_reg + ram_rdata;
                    end
                    if (d_in_sum && d_reg >= abfx_pkg::CNT_W'(abfx_pkg::HDR_BYTES))
                    begin
                        for (int k = 0; k < abfx_pkg::MAX_PAYLOAD; k++)
                        begin
                            if (psel_rx == abfx_pkg::PSEL_W'(k))
                            begin
                                rpay_next[8*k +: 8] = ram_rdata;
                            end
                        end
                    end
                    if (9'(d_reg) == len_chk)
                    begin
                        chk_next = ram_rdata;
                    end
                end
            end
            abfx_pkg::B_CHECK:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_kind     = abfx_pkg::OUT_STATUS;
                    out_next.tx_byte      = '0;
                    out_next.last         = 1'b1;
                    out_next.status       = ((8'd0 - sum_reg) == chk_reg) ?
                                            abfx_pkg::ST_OK : abfx_pkg::ST_CHECKSUM;
                    out_next.resp_length  = rlen_reg;
                    out_next.resp_source  = rsrc_reg;
                    out_next.resp_dest    = rdst_reg;
                    out_next.resp_id      = rid_reg;
                    out_next.resp_payload = rpay_reg;
                    bstat.check_done      = 1'b1;
                end
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abfx_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            dvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dvalid_reg    <= dvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        ptr_reg  <= ptr_next;
        d_reg    <= d_next;
        chk_reg  <= chk_next;
        rlen_reg <= rlen_next;
        rsrc_reg <= rsrc_next;
        rdst_reg <= rdst_next;
        rid_reg  <= rid_next;
        rpay_reg <= rpay_next;
        out_reg  <= out_next;
    end

    // Jobs leave the queue only when the back end is free
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == abfx_pkg::B_IDLE)
        else $error("job popped while back end busy");

    // Frame byte counter never runs past the checksum byte
    a_send_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == abfx_pkg::B_SEND |->
            {{(8 - abfx_pkg::IDX_W){1'b0}}, idx_reg} <=
            job_reg.size + 8'(abfx_pkg::HDR_BYTES))
        else $error("frame byte index past checksum");

    // Read pointer stays within one past the walk end
    a_walk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == abfx_pkg::B_WALK |-> ptr_reg <= walk_end + 1'b1)
        else $error("buffer walk overran");

    // A completed check shows up as a final status beat
    a_check_beat: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.check_done |=> out_valid_reg && out_reg.last &&
            out_reg.out_kind == abfx_pkg::OUT_STATUS)
        else $error("check completion without status beat");

endmodule

`default_nettype wire

[rtl/core/aux_bus_frame_exchange.sv]
// Top level of the AUX bus frame exchange: front, job queue, receive buffer and back.
//
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------------
//  item     | in  | cmd, dest, msg_id, size, payload, rx_byte, busy_level
//  result   | out | out_kind, tx_byte, last, status, resp_* fields
//  wr_*     | in  | wr_index selects source address or timeout, wr_data
//
//  A send gives size + 6 byte beats, one per cycle while result is ready, after
//  passing through the job queue. A response check reads max(4, length + 2)
//  buffer bytes at one per cycle from the single RAM read port, then gives one
//  status beat; item is held off until that beat is loaded. Reset is
//  asynchronous; there is no clearing pass. A stalled result stalls the back
//  end only; the front keeps taking items until the two-entry queue fills or
//  a response check is pending.
`default_nettype none

module aux_bus_frame_exchange (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    abfx_item_if.sink                               item,
    abfx_result_if.source                           result,
    input  wire logic                               wr_en,
    input  wire logic [abfx_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [abfx_pkg::CFG_DATA_W-1:0]    wr_data
);

    logic                           q_push;
    abfx_pkg::job_t                 q_job;
    logic                           q_full;
    logic                           q_valid;
    abfx_pkg::job_t                 q_head;
    logic                           q_pop;
    abfx_pkg::back_stat_t           bstat;
    logic                           ram_we;
    logic [abfx_pkg::IDX_W-1:0]     ram_waddr;
    logic [7:0]                     ram_wdata;
    logic [abfx_pkg::IDX_W-1:0]     ram_raddr;
    logic [7:0]                     ram_rdata;

    abfx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .q_push    (q_push),
        .q_job     (q_job),
        .q_full    (q_full),
        .bstat     (bstat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    abfx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    abfx_ram #(
        .WIDTH (8),
        .DEPTH (abfx_pkg::RX_DEPTH)
    ) u_rx_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    abfx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_head),
        .q_pop     (q_pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .bstat     (bstat),
        .result    (result)
    );

endmodule

`default_nettype wire
